>>> design/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpc_pkg
// Shared types and constants of the triangle plane clipper.
// ---------------------------------------------------------------------------
package tpc_pkg;

   localparam int CoordWidth     = 32;
   localparam int FracBits       = 16;
   localparam int DiffWidth      = CoordWidth + 1;
   localparam int ProdWidth      = 2 * CoordWidth + 1;
   localparam int DistWidth      = 2 * CoordWidth + 2;
   localparam int DenWidth       = DistWidth;
   localparam int MagWidth       = CoordWidth + 1;
   localparam int QueueDepth     = 8;
   localparam int QueuePtrWidth  = $clog2(QueueDepth);
   localparam int QueueCntWidth  = $clog2(QueueDepth + 1);
   localparam int CsrAddrWidth   = 5;
   localparam int CsrDataWidth   = 32;
   localparam int CsrIndexWidth  = CsrAddrWidth - 2;

   localparam logic [CoordWidth-1:0] NormalZReset = CoordWidth'(64'd1 << FracBits);

   localparam logic [CsrIndexWidth-1:0] RegNormalX = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] RegNormalY = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] RegNormalZ = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] RegPointX  = CsrIndexWidth'(3);
   localparam logic [CsrIndexWidth-1:0] RegPointY  = CsrIndexWidth'(4);
   localparam logic [CsrIndexWidth-1:0] RegPointZ  = CsrIndexWidth'(5);

   localparam logic [1:0] ClipWhole   = 2'd0;
   localparam logic [1:0] ClipCropped = 2'd1;
   localparam logic [1:0] ClipDoubled = 2'd2;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef coord_type [2:0] vertex_type;
   typedef logic signed [DistWidth-1:0] dist_type;

   typedef struct packed {
      coord_type vert0_x;
      coord_type vert0_y;
      coord_type vert0_z;
      coord_type vert1_x;
      coord_type vert1_y;
      coord_type vert1_z;
      coord_type vert2_x;
      coord_type vert2_y;
      coord_type vert2_z;
   } tpc_req_type;

   typedef struct packed {
      coord_type  out0_x;
      coord_type  out0_y;
      coord_type  out0_z;
      coord_type  out1_x;
      coord_type  out1_y;
      coord_type  out1_z;
      coord_type  out2_x;
      coord_type  out2_y;
      coord_type  out2_z;
      logic [1:0] clip_status;
      logic       last_of_run;
   } tpc_rsp_type;

   typedef struct packed {
      vertex_type [2:0] vert;
      dist_type   [2:0] sdist;
      logic       [2:0] in_mask;
   } tpc_item_type;

   typedef struct packed {
      vertex_type [2:0]      corner;
      logic       [1:0]      status;
      logic       [1:0][2:0] neg;
   } tpc_side_type;

endpackage
`default_nettype wire

>>> design/tpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpc_front
// Three-stage plane distance pipeline and inside/outside classification.
// ---------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  tpc_req_type  in_data,
   input  vertex_type   normal,
   input  vertex_type   point,
   output logic         out_valid,
   output tpc_item_type out_item,
   output logic [1:0]   occupancy
);

   vertex_type v_in [3];

   logic vld1_ff, vld2_ff, vld3_ff;
   vertex_type vert1_ff [3];
   vertex_type vert2_ff [3];
   vertex_type vert3_ff [3];
   logic signed [DiffWidth-1:0] diff_ff [3][3];
   logic signed [DiffWidth-1:0] diff_in [3][3];
   logic signed [ProdWidth-1:0] prod_ff [3][3];
   logic signed [ProdWidth-1:0] prod_in [3][3];
   dist_type dist_ff [3];
   dist_type dist_in [3];
   logic [2:0] in_mask;

   always_comb begin
      v_in[0][0] = in_data.vert0_x;
      v_in[0][1] = in_data.vert0_y;
      v_in[0][2] = in_data.vert0_z;
      v_in[1][0] = in_data.vert1_x;
      v_in[1][1] = in_data.vert1_y;
      v_in[1][2] = in_data.vert1_z;
      v_in[2][0] = in_data.vert2_x;
      v_in[2][1] = in_data.vert2_y;
      v_in[2][2] = in_data.vert2_z;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            diff_in[i][k] = DiffWidth'($signed(v_in[i][k])) - DiffWidth'($signed(point[k]));
            prod_in[i][k] = ProdWidth'(diff_ff[i][k]) * ProdWidth'($signed(normal[k]));
         end
         dist_in[i] = DistWidth'(prod_ff[i][0]) + DistWidth'(prod_ff[i][1])
                    + DistWidth'(prod_ff[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         vert1_ff[i] <= v_in[i];
         vert2_ff[i] <= vert1_ff[i];
         vert3_ff[i] <= vert2_ff[i];
         dist_ff[i]  <= dist_in[i];
         for (int k = 0; k < 3; k++) begin
            diff_ff[i][k] <= diff_in[i][k];
            prod_ff[i][k] <= prod_in[i][k];
         end
      end
   end

   // zero distance counts as inside
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_mask[i]        = ~dist_ff[i][DistWidth-1];
         out_item.vert[i]  = vert3_ff[i];
         out_item.sdist[i] = dist_ff[i];
      end
      out_item.in_mask = in_mask;
   end

   // triangles wholly outside give no item downstream
   assign out_valid = vld3_ff & (|in_mask);
   assign occupancy = 2'(vld1_ff) + 2'(vld2_ff) + 2'(vld3_ff);

endmodule
`default_nettype wire

>>> design/tpc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpc_queue
// Short item queue between the classifying front and the cutting back.
// ---------------------------------------------------------------------------
module tpc_queue import tpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  tpc_item_type             push_item,
   input  logic                     pop,
   output logic                     head_valid,
   output tpc_item_type             head_item,
   output logic [QueueCntWidth-1:0] count
);

   tpc_item_type mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntWidth-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("item taken from empty queue");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != QueueCntWidth'(QueueDepth)) else $error("item lost on full queue");

endmodule
`default_nettype wire

>>> design/tpc_cut_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpc_cut_pipe
// Pipelined restoring divider: offset = |e-s|*ds/den for x, y and z of both cut
// edges, each stage adding one quotient digit (0, 1 or 2), then round to nearest.
// ---------------------------------------------------------------------------
module tpc_cut_pipe import tpc_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [1:0][DenWidth-1:0]        in_den,
   input  logic [1:0][DenWidth-1:0]        in_ds,
   input  logic [1:0][2:0][MagWidth-1:0]   in_mag,
   input  tpc_side_type                    in_side,
   output logic                            out_valid,
   output logic [1:0][2:0][MagWidth-1:0]   out_q,
   output tpc_side_type                    out_side
);

   localparam int Stages   = MagWidth;
   localparam int ExtWidth = DenWidth + 3;

   logic [Stages:0] vld_ff;
   logic [1:0][DenWidth-1:0]      den_ff [Stages+1];
   logic [1:0][DenWidth-1:0]      ds_ff  [Stages+1];
   logic [1:0][2:0][DenWidth-1:0] rem_ff [Stages+1];
   logic [1:0][2:0][MagWidth-1:0] quo_ff [Stages+1];
   logic [1:0][2:0][MagWidth-1:0] mag_ff [Stages+1];
   tpc_side_type                  side_ff [Stages+1];

   logic [1:0][2:0][DenWidth-1:0] rem_in [Stages];
   logic [1:0][2:0][MagWidth-1:0] quo_in [Stages];

   logic                          out_vld_ff;
   logic [1:0][2:0][MagWidth-1:0] out_q_ff, out_q_in;
   tpc_side_type                  out_side_ff;

   // r < den and ds < den, so 2r + ds lies below 3*den: at most two subtracts
   always_comb begin
      logic [ExtWidth-1:0] acc, t1, t2;
      for (int j = 0; j < Stages; j++) begin
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 3; k++) begin
               acc = (ExtWidth'(rem_ff[j][c][k]) << 1)
                   + (mag_ff[j][c][k][MagWidth-1] ? ExtWidth'(ds_ff[j][c]) : '0);
               t1  = acc - ExtWidth'(den_ff[j][c]);
               t2  = acc - (ExtWidth'(den_ff[j][c]) << 1);
               if (!t2[ExtWidth-1]) begin
                  rem_in[j][c][k] = DenWidth'(t2);
                  quo_in[j][c][k] = (quo_ff[j][c][k] << 1) + MagWidth'(2);
               end else if (!t1[ExtWidth-1]) begin
                  rem_in[j][c][k] = DenWidth'(t1);
                  quo_in[j][c][k] = (quo_ff[j][c][k] << 1) + MagWidth'(1);
               end else begin
                  rem_in[j][c][k] = DenWidth'(acc);
                  quo_in[j][c][k] = quo_ff[j][c][k] << 1;
               end
            end
         end
      end
   end

   // round half away from zero on the magnitude
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 3; k++) begin
            out_q_in[c][k] = quo_ff[Stages][c][k]
               + MagWidth'(((DenWidth + 1)'(rem_ff[Stages][c][k]) << 1)
                           >= (DenWidth + 1)'(den_ff[Stages][c]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[Stages-1:0], in_valid};
         out_vld_ff <= vld_ff[Stages];
      end
   end

   always_ff @(posedge clock) begin
      den_ff[0]  <= in_den;
      ds_ff[0]   <= in_ds;
      rem_ff[0]  <= '0;
      quo_ff[0]  <= '0;
      mag_ff[0]  <= in_mag;
      side_ff[0] <= in_side;
      for (int j = 0; j < Stages; j++) begin
         den_ff[j+1]  <= den_ff[j];
         ds_ff[j+1]   <= ds_ff[j];
         rem_ff[j+1]  <= rem_in[j];
         quo_ff[j+1]  <= quo_in[j];
         side_ff[j+1] <= side_ff[j];
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 3; k++) begin
               mag_ff[j+1][c][k] <= mag_ff[j][c][k] << 1;
            end
         end
      end
      out_q_ff    <= out_q_in;
      out_side_ff <= side_ff[Stages];
   end

   assign out_valid = out_vld_ff;
   assign out_q     = out_q_ff;
   assign out_side  = out_side_ff;

endmodule
`default_nettype wire

>>> design/tpc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tpc_back
// Picks cut edges for each queued item, runs the divider pipeline and
// assembles one or two result triangles.
// ---------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  tpc_item_type head_item,
   output logic         pop,
   output logic         rsp_valid,
   output tpc_rsp_type  rsp_data
);

   function automatic tpc_rsp_type make_rsp(vertex_type a, vertex_type b, vertex_type c,
                                            logic [1:0] st, logic last);
      tpc_rsp_type r;
      r.out0_x      = a[0];
      r.out0_y      = a[1];
      r.out0_z      = a[2];
      r.out1_x      = b[0];
      r.out1_y      = b[1];
      r.out1_z      = b[2];
      r.out2_x      = c[0];
      r.out2_y      = c[1];
      r.out2_z      = c[2];
      r.clip_status = st;
      r.last_of_run = last;
      return r;
   endfunction

   logic gap_ff, gap_in;
   logic [1:0] ia_s, ia_e, ib_s, ib_e, iw0, iw1, iw2;
   logic [1:0] status;

   logic [1:0][DenWidth-1:0]      den, ds;
   logic [1:0][2:0][MagWidth-1:0] mag;
   tpc_side_type                  side;
   logic [DiffWidth-1:0]          delta;

   logic                          pipe_valid;
   logic [1:0][2:0][MagWidth-1:0] pipe_q;
   tpc_side_type                  pipe_side;

   vertex_type  cut_a, cut_b, base_b;
   tpc_rsp_type first_rsp, second_rsp;

   logic        rsp_valid_ff, rsp_valid_in;
   tpc_rsp_type rsp_data_ff, rsp_data_in;
   logic        pend_ff, pend_in;
   tpc_rsp_type pend_data_ff;

   // inside vertices keep input order; so do outside ones
   always_comb begin
      ia_s = 2'd0; ia_e = 2'd1; ib_s = 2'd0; ib_e = 2'd2;
      iw0 = 2'd0; iw1 = 2'd1; iw2 = 2'd2;
      status = ClipWhole;
      case (head_item.in_mask)
         3'b001: begin
            status = ClipCropped;
            iw0 = 2'd0; iw1 = 2'd1; iw2 = 2'd2;
            ia_s = 2'd0; ia_e = 2'd1; ib_s = 2'd0; ib_e = 2'd2;
         end
         3'b010: begin
            status = ClipCropped;
            iw0 = 2'd1; iw1 = 2'd0; iw2 = 2'd2;
            ia_s = 2'd1; ia_e = 2'd0; ib_s = 2'd1; ib_e = 2'd2;
         end
         3'b100: begin
            status = ClipCropped;
            iw0 = 2'd2; iw1 = 2'd0; iw2 = 2'd1;
            ia_s = 2'd2; ia_e = 2'd0; ib_s = 2'd2; ib_e = 2'd1;
         end
         3'b011: begin
            status = ClipDoubled;
            iw0 = 2'd0; iw1 = 2'd2; iw2 = 2'd1;
            ia_s = 2'd0; ia_e = 2'd2; ib_s = 2'd1; ib_e = 2'd2;
         end
         3'b101: begin
            status = ClipDoubled;
            iw0 = 2'd0; iw1 = 2'd1; iw2 = 2'd2;
            ia_s = 2'd0; ia_e = 2'd1; ib_s = 2'd2; ib_e = 2'd1;
         end
         3'b110: begin
            status = ClipDoubled;
            iw0 = 2'd1; iw1 = 2'd0; iw2 = 2'd2;
            ia_s = 2'd1; ia_e = 2'd0; ib_s = 2'd2; ib_e = 2'd0;
         end
         default: begin
            status = ClipWhole;
         end
      endcase
   end

   // a doubled item leaves the next pipeline slot empty for its second triangle
   assign pop    = head_valid & ~gap_ff;
   assign gap_in = pop & (status == ClipDoubled);

   always_comb begin
      delta = '0;
      den[0] = DenWidth'(head_item.sdist[ia_s] - head_item.sdist[ia_e]);
      den[1] = DenWidth'(head_item.sdist[ib_s] - head_item.sdist[ib_e]);
      ds[0]  = DenWidth'(head_item.sdist[ia_s]);
      ds[1]  = DenWidth'(head_item.sdist[ib_s]);
      for (int k = 0; k < 3; k++) begin
         delta = DiffWidth'($signed(head_item.vert[ia_e][k]))
               - DiffWidth'($signed(head_item.vert[ia_s][k]));
         side.neg[0][k] = delta[DiffWidth-1];
         mag[0][k] = delta[DiffWidth-1] ? MagWidth'(-delta) : MagWidth'(delta);
         delta = DiffWidth'($signed(head_item.vert[ib_e][k]))
               - DiffWidth'($signed(head_item.vert[ib_s][k]));
         side.neg[1][k] = delta[DiffWidth-1];
         mag[1][k] = delta[DiffWidth-1] ? MagWidth'(-delta) : MagWidth'(delta);
      end
      side.corner[0] = head_item.vert[iw0];
      side.corner[1] = head_item.vert[iw1];
      side.corner[2] = head_item.vert[iw2];
      side.status    = status;
   end

   tpc_cut_pipe u_cut_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .in_den    (den),
      .in_ds     (ds),
      .in_mag    (mag),
      .in_side   (side),
      .out_valid (pipe_valid),
      .out_q     (pipe_q),
      .out_side  (pipe_side)
   );

   always_comb begin
      base_b = (pipe_side.status == ClipCropped) ? pipe_side.corner[0] : pipe_side.corner[2];
      for (int k = 0; k < 3; k++) begin
         cut_a[k] = pipe_side.neg[0][k]
                  ? pipe_side.corner[0][k] - CoordWidth'(pipe_q[0][k])
                  : pipe_side.corner[0][k] + CoordWidth'(pipe_q[0][k]);
         cut_b[k] = pipe_side.neg[1][k]
                  ? base_b[k] - CoordWidth'(pipe_q[1][k])
                  : base_b[k] + CoordWidth'(pipe_q[1][k]);
      end
      case (pipe_side.status)
         ClipCropped: first_rsp = make_rsp(pipe_side.corner[0], cut_a, cut_b,
                                           ClipCropped, 1'b1);
         ClipDoubled: first_rsp = make_rsp(pipe_side.corner[0], cut_a, pipe_side.corner[2],
                                           ClipDoubled, 1'b0);
         default:     first_rsp = make_rsp(pipe_side.corner[0], pipe_side.corner[1],
                                           pipe_side.corner[2], ClipWhole, 1'b1);
      endcase
      second_rsp = make_rsp(cut_a, cut_b, pipe_side.corner[2], ClipDoubled, 1'b1);
   end

   assign rsp_valid_in = pipe_valid | pend_ff;
   assign rsp_data_in  = pipe_valid ? first_rsp : pend_data_ff;
   assign pend_in      = pipe_valid & (pipe_side.status == ClipDoubled);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gap_ff       <= gap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (pipe_valid) begin
         pend_data_ff <= second_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pend_slot_free : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !pipe_valid) else $error("second triangle collides with next item");

   a_doubled_pair : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last_of_run
      |=> rsp_valid_ff && rsp_data_ff.clip_status == ClipDoubled)
      else $error("first of a doubled pair not followed by its second");

endmodule
`default_nettype wire

>>> design/triangle_plane_clipper_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_plane_clipper_unit
// Clips one triangle against a programmable plane, giving zero, one or two
// result triangles.
// ---------------------------------------------------------------------------
// results: the second triangle of a doubled item comes in the cycle after its first
// throughput: one item a cycle while items give one triangle; an item that gives
//   two holds back the next pop for its second triangle, as set by the single
//   result port
// reset: clears plane registers to normal (0,0,1.0), point at origin; no
//   clearing pass, the block takes items in the first cycle after reset
module triangle_plane_clipper_unit import tpc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tpc_req_type             req_data,
   output logic                    rsp_valid,
   output tpc_rsp_type             rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   localparam int SumWidth = QueueCntWidth + 1;

   vertex_type normal_ff, point_ff;
   logic [CsrIndexWidth-1:0] csr_index;
   logic csr_write;

   logic         accept;
   logic         front_valid;
   tpc_item_type front_item;
   logic [1:0]   front_occ;
   logic         head_valid, pop;
   tpc_item_type head_item;
   logic [QueueCntWidth-1:0] queue_count;

   assign csr_index = paddr[CsrAddrWidth-1:2];
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NormalZReset;
         point_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            RegNormalX: normal_ff[0] <= CoordWidth'(pwdata);
            RegNormalY: normal_ff[1] <= CoordWidth'(pwdata);
            RegNormalZ: normal_ff[2] <= CoordWidth'(pwdata);
            RegPointX:  point_ff[0]  <= CoordWidth'(pwdata);
            RegPointY:  point_ff[1]  <= CoordWidth'(pwdata);
            RegPointZ:  point_ff[2]  <= CoordWidth'(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         RegNormalX: prdata = CsrDataWidth'(normal_ff[0]);
         RegNormalY: prdata = CsrDataWidth'(normal_ff[1]);
         RegNormalZ: prdata = CsrDataWidth'(normal_ff[2]);
         RegPointX:  prdata = CsrDataWidth'(point_ff[0]);
         RegPointY:  prdata = CsrDataWidth'(point_ff[1]);
         RegPointZ:  prdata = CsrDataWidth'(point_ff[2]);
         default:    prdata = '0;
      endcase
   end

   // every item in the front pipe holds a queue slot in reserve
   assign busy   = (SumWidth'(front_occ) + SumWidth'(queue_count)) >= SumWidth'(QueueDepth);
   assign accept = start & ~busy;

   tpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .normal    (normal_ff),
      .point     (point_ff),
      .out_valid (front_valid),
      .out_item  (front_item),
      .occupancy (front_occ)
   );

   tpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_item  (front_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   tpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
